// ===== design/wrd_pkg.sv =====
// Shared sizes, request codes and the tuple addressing function for the
// weightless RAM discriminator. Used by the top level and its testbench.
package wrd_pkg;

  localparam int TUPLE_BITS = 8;
  localparam int NEURONS    = 8;
  localparam int INPUT_BITS = 64;
  localparam int PATTERN_W  = 64;

  localparam int ADDR_W   = TUPLE_BITS;
  localparam int COUNT_W  = 4;
  localparam int SUM_W    = $clog2(NEURONS + 1);
  localparam int CMP_W    = (SUM_W > COUNT_W) ? SUM_W : COUNT_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [0:0] {
    REQ_TRAIN = 1'b0,
    REQ_SCORE = 1'b1
  } req_t;

  // Address of neuron k: its contiguous group of pattern bits, lowest bit as
  // the least significant address bit. Bits past the pattern read as zero.
  function automatic logic [ADDR_W-1:0] tuple_addr(input logic [PATTERN_W-1:0] pat,
                                                   input int k);
    logic [ADDR_W-1:0] addr;
    int                pos;
    addr = '0;
    for (int b = 0; b < TUPLE_BITS; b++) begin
      pos = k * TUPLE_BITS + b;
      if (pos < INPUT_BITS && pos < PATTERN_W) begin
        addr[b] = pat[pos];
      end
    end
    return addr;
  endfunction

endpackage

// ===== design/wrd_neuron_ram.sv =====
// One-bit-wide synchronous RAM holding the cells of a single neuron.
// One write port and one registered read port; no dependencies.
module wrd_neuron_ram #(
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/weightless_ram_discriminator_core.sv =====
// Weightless RAM discriminator: one bit RAM per neuron, addressed by the
// neuron's group of pattern bits. Depends on wrd_pkg and wrd_neuron_ram.
//
// After reset the block clears every neuron RAM, one row in all neurons per
// cycle, with in_ready low. After that it takes one item per cycle unless
// back-pressure on the output fills the read stage. A train item sets the
// addressed bit of each neuron at the cycle of its transfer and gives no
// result. A score item reads all neuron RAMs in parallel at its transfer;
// the RAM read data is registered, then the count goes into the output
// register. Input and output are parted by that register, so the block keeps
// taking items while a result waits, until the read stage is also full.
module weightless_ram_discriminator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [wrd_pkg::PATTERN_W-1:0] pattern,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [wrd_pkg::COUNT_W-1:0]   match_count
);

  logic                         clearing;
  logic [wrd_pkg::ADDR_W-1:0]   clr_addr;
  logic                         s1_valid;
  logic                         s1_advance;
  logic                         in_xfer;
  logic                         train_xfer;
  logic                         score_xfer;
  logic [wrd_pkg::NEURONS-1:0]  hit;
  logic [wrd_pkg::CMP_W-1:0]    sum;
  logic [wrd_pkg::COUNT_W-1:0]  match_count_next;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !clearing && (!s1_valid || s1_advance);
  assign in_xfer    = in_valid && in_ready;
  assign train_xfer = in_xfer && (req_type == wrd_pkg::REQ_TRAIN);
  assign score_xfer = in_xfer && (req_type == wrd_pkg::REQ_SCORE);

  // Clearing pass: one row of every neuron per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < wrd_pkg::NEURONS; k++) begin : g_neuron
    logic [wrd_pkg::ADDR_W-1:0] addr;
    assign addr = wrd_pkg::tuple_addr(pattern, k);

    wrd_neuron_ram #(
      .ADDR_W (wrd_pkg::ADDR_W)
    ) u_ram (
      .clk   (clk),
      .we    (clearing || train_xfer),
      .waddr (clearing ? clr_addr : addr),
      .wdata (!clearing),
      .re    (score_xfer),
      .raddr (addr),
      .rdata (hit[k])
    );
  end

  // The read data holds while the read stage waits, as only a score
  // transfer issues a new read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (score_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < wrd_pkg::NEURONS; k++) begin
      sum = sum + wrd_pkg::CMP_W'(hit[k]);
    end
    if (sum > wrd_pkg::CMP_W'(wrd_pkg::COUNT_MAX)) begin
      match_count_next = wrd_pkg::COUNT_MAX;
    end else begin
      match_count_next = sum[wrd_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      match_count <= match_count_next;
    end
  end

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !out_valid)
    else $error("item in flight during clearing pass");

  a_train_no_result: assert property (@(posedge clk) disable iff (rst)
    train_xfer |=> !s1_valid)
    else $error("train transfer produced a pending read");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_count <= wrd_pkg::COUNT_W'(wrd_pkg::NEURONS))
    else $error("match count above neuron count");

endmodule

// ===== bench/weightless_ram_discriminator_core_test.sv =====
// Self-checking testbench for weightless_ram_discriminator_core: directed table, then
// random train and score traffic under varying back-pressure. Depends on wrd_pkg and the RTL.
module weightless_ram_discriminator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS_PER_NEURON = 2 ** wrd_pkg::TUPLE_BITS;
  localparam int PREDICTED        = -1;
  localparam int RANDOM_PER_PHASE = 260;
  localparam int REPORT_LIMIT     = 10;
  // Far beyond the slowest legal run: clearing pass plus roughly 800 items
  // with either side stalling at most about half the time.
  localparam int CYCLE_LIMIT      = 200000;

  typedef struct {
    wrd_pkg::req_t                 kind;
    logic [wrd_pkg::PATTERN_W-1:0] pat;
    int                            typed_count;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          req_type = wrd_pkg::REQ_TRAIN;
  logic [wrd_pkg::PATTERN_W-1:0] pattern = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [wrd_pkg::COUNT_W-1:0]   match_count;

  bit                            neuron_cells [wrd_pkg::NEURONS][CELLS_PER_NEURON];
  logic [wrd_pkg::COUNT_W-1:0]   pending_counts [$];
  logic [wrd_pkg::PATTERN_W-1:0] base_patterns [8];
  logic [15:0]                   counts_seen = '0;
  int                            sender_idle_pct = 13;
  int                            receiver_idle_pct = 49;
  int                            failures = 0;
  int                            trains_sent = 0;
  int                            scores_sent = 0;
  int                            results_checked = 0;
  int                            cycle_count = 0;

  // Rows with a typed count are read straight off the behaviour; the rest
  // take their expectation from the predictor.
  stim_row_t directed_rows [23] = '{
    '{wrd_pkg::REQ_SCORE, 64'h0000_0000_0000_0000, 0},
    '{wrd_pkg::REQ_SCORE, 64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{wrd_pkg::REQ_SCORE, 64'h8000_0000_0000_0001, 0},
    '{wrd_pkg::REQ_TRAIN, 64'h0000_0000_0000_0000, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'h0000_0000_0000_0000, 8},
    '{wrd_pkg::REQ_SCORE, 64'hFFFF_FFFF_FFFF_FFFF, 0},
    '{wrd_pkg::REQ_TRAIN, 64'h0000_0000_0000_0000, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'h0000_0000_0000_0000, 8},
    '{wrd_pkg::REQ_TRAIN, 64'hFFFF_FFFF_FFFF_FFFF, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'hFFFF_FFFF_FFFF_FFFF, 8},
    '{wrd_pkg::REQ_SCORE, 64'hFFFF_FFFF_0000_0000, 8},
    '{wrd_pkg::REQ_SCORE, 64'h0000_0000_0000_00FF, 8},
    '{wrd_pkg::REQ_SCORE, 64'h0000_0000_0000_0002, PREDICTED},
    '{wrd_pkg::REQ_TRAIN, 64'h0101_0101_0101_0101, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'h0101_0101_0000_0000, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'h0202_0202_0202_0202, PREDICTED},
    '{wrd_pkg::REQ_TRAIN, 64'hA55A_3CC3_0FF0_1234, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'hA55A_3CC3_0FF0_1234, 8},
    '{wrd_pkg::REQ_SCORE, 64'hA55A_3CC3_0000_0000, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'h0000_0000_0000_0080, PREDICTED},
    '{wrd_pkg::REQ_TRAIN, 64'h8000_0000_0000_0000, PREDICTED},
    '{wrd_pkg::REQ_SCORE, 64'h8000_0000_0000_0000, 8},
    '{wrd_pkg::REQ_SCORE, 64'h7FFF_FFFF_FFFF_FFFF, PREDICTED}
  };

  weightless_ram_discriminator_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .pattern     (pattern),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .match_count (match_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_counts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Pattern bits past INPUT_BITS are cleared before the group is cut out,
  // and a shift past the top of the pattern leaves zeros.
  function automatic logic [wrd_pkg::TUPLE_BITS-1:0] neuron_address(
    logic [wrd_pkg::PATTERN_W-1:0] pat, int k);
    logic [wrd_pkg::PATTERN_W-1:0] live;
    logic [wrd_pkg::PATTERN_W-1:0] shifted;
    live = pat;
    for (int p = wrd_pkg::INPUT_BITS; p < wrd_pkg::PATTERN_W; p++) live[p] = 1'b0;
    shifted = live >> (k * wrd_pkg::TUPLE_BITS);
    return shifted[wrd_pkg::TUPLE_BITS-1:0];
  endfunction

  function automatic logic [wrd_pkg::PATTERN_W-1:0] random_pattern();
    return {$urandom, $urandom};
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
  endtask

  // Updates the neuron copy for one accepted transfer and queues the count
  // that a score must produce.
  task automatic train_or_score(wrd_pkg::req_t kind, logic [wrd_pkg::PATTERN_W-1:0] pat,
                                int typed_count);
    logic [wrd_pkg::TUPLE_BITS-1:0] addr;
    int                             hits;
    hits = 0;
    for (int k = 0; k < wrd_pkg::NEURONS; k++) begin
      addr = neuron_address(pat, k);
      if (kind == wrd_pkg::REQ_TRAIN) begin
        neuron_cells[k][addr] = 1'b1;
      end else if (neuron_cells[k][addr] && hits < int'(wrd_pkg::COUNT_MAX)) begin
        hits++;
      end
    end
    if (kind == wrd_pkg::REQ_SCORE) begin
      scores_sent++;
      pending_counts.push_back((typed_count >= 0) ? wrd_pkg::COUNT_W'(typed_count)
                                                  : wrd_pkg::COUNT_W'(hits));
    end else begin
      trains_sent++;
    end
  endtask

  // Called at a rising edge; returns at the edge where the item transferred.
  task automatic transfer_item(wrd_pkg::req_t kind, logic [wrd_pkg::PATTERN_W-1:0] pat,
                               int typed_count);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    pattern  <= pat;
    do @(posedge clk); while (!in_ready);
    train_or_score(kind, pat, typed_count);
  endtask

  initial begin
    logic [wrd_pkg::COUNT_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_checked++;
        counts_seen[match_count] = 1'b1;
        if (pending_counts.size() == 0) begin
          note_failure($sformatf("unexpected result, match_count %0d", match_count));
        end else begin
          want = pending_counts.pop_front();
          if (match_count !== want) begin
            note_failure($sformatf("match_count expected %0d, got %0d", want, match_count));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  initial begin
    wrd_pkg::req_t                 kind;
    logic [wrd_pkg::PATTERN_W-1:0] pat;
    int                            roll;
    int                            groups;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      transfer_item(directed_rows[i].kind, directed_rows[i].pat, directed_rows[i].typed_count);
    end

    // A small pool of base patterns; trains and most scores are variants of them
    // with some groups replaced, so match counts spread over the whole range.
    foreach (base_patterns[i]) base_patterns[i] = random_pattern();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 13;
          receiver_idle_pct = 49;
        end
        1: begin
          sender_idle_pct   = 49;
          receiver_idle_pct = 13;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        pat  = base_patterns[$urandom_range(0, 7)];
        if (roll < 30) begin
          kind = wrd_pkg::REQ_TRAIN;
          if ($urandom_range(0, 99) < 40) begin
            pat = random_pattern();
          end else begin
            groups = $urandom_range(0, 2);
            for (int g = 0; g < groups; g++) begin
              pat[$urandom_range(0, wrd_pkg::NEURONS - 1) * wrd_pkg::TUPLE_BITS
                  +: wrd_pkg::TUPLE_BITS] = wrd_pkg::TUPLE_BITS'($urandom);
            end
          end
        end else begin
          kind = wrd_pkg::REQ_SCORE;
          if (roll < 45) begin
            pat = random_pattern();
          end else begin
            groups = $urandom_range(0, wrd_pkg::NEURONS);
            for (int g = 0; g < groups; g++) begin
              pat[$urandom_range(0, wrd_pkg::NEURONS - 1) * wrd_pkg::TUPLE_BITS
                  +: wrd_pkg::TUPLE_BITS] = wrd_pkg::TUPLE_BITS'($urandom);
            end
          end
        end
        transfer_item(kind, pat, PREDICTED);
      end
    end
    in_valid <= 1'b0;

    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d train and %0d score transfers; %0d results checked.",
             trains_sent, scores_sent, results_checked);
    $display("Match counts observed (bit per value): %b; failures: %0d", counts_seen, failures);
    if (failures == 0 && pending_counts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
